FILE: rtl/nll_pkg.sv
`default_nettype none
package nll_pkg;

    localparam int MAX_LENGTH = 255;
    // consumed_length is 8 bits wide, so the count never passes 255
    localparam int LEN_LIMIT_I = (MAX_LENGTH > 255) ? 255 : MAX_LENGTH;
    localparam logic [7:0] LEN_LIMIT = 8'(LEN_LIMIT_I);

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 4;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UE    = 8'h45;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_SIGNED = 4'd1,
        PH_INT    = 4'd2,
        PH_FRAC   = 4'd3,
        PH_ESIGN  = 4'd4,
        PH_EXP    = 4'd5,
        PH_ZERO   = 4'd6,
        PH_HEX    = 4'd7,
        PH_BIN    = 4'd8,
        PH_OCT    = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        K_DEC = 3'd0,
        K_DBL = 3'd1,
        K_FLT = 3'd2,
        K_OCT = 3'd3,
        K_HEX = 3'd4,
        K_BIN = 3'd5
    } t_kind;

    // scan state; nacc tracks the negated accumulator alongside acc
    typedef struct packed {
        t_phase      phase;
        logic        minus;
        t_kind       kind;
        logic [63:0] acc;
        logic [63:0] nacc;
        logic [7:0]  len;
    } t_scan;

    typedef struct packed {
        logic        had_minus;
        logic [7:0]  len;
        logic [63:0] value;
        t_kind       kind;
        logic        found;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/nll_step.sv
`default_nettype none
module nll_step (
    input  wire nll_pkg::t_scan   i_scan,
    input  wire logic [7:0]       i_char,
    input  wire logic             i_eot,
    output nll_pkg::t_scan        o_scan,
    output logic                  o_emit,
    output nll_pkg::t_result      o_result
);
    import nll_pkg::*;

    logic       is_dig, is_oct, is_bin, is_e, is_f, is_sign, is_hex;
    logic [3:0] dig, hexv;
    logic [7:0] len_inc;

    assign is_dig  = (i_char >= CH_0) && (i_char <= CH_9);
    assign is_oct  = (i_char >= CH_0) && (i_char <= CH_7);
    assign is_bin  = (i_char == CH_0) || (i_char == CH_1);
    assign is_e    = (i_char == CH_LE) || (i_char == CH_UE);
    assign is_f    = (i_char == CH_LF) || (i_char == CH_UF);
    assign is_sign = (i_char == CH_PLUS) || (i_char == CH_MINUS);
    assign dig     = i_char[3:0];

    always_comb begin
        is_hex = 1'b1;
        hexv   = dig;
        if (is_dig) begin
            hexv = dig;
        end else if ((i_char >= CH_LA) && (i_char <= CH_LF)) begin
            hexv = 4'(i_char - CH_LA + 8'd10);
        end else if ((i_char >= CH_UA) && (i_char <= CH_UF)) begin
            hexv = 4'(i_char - CH_UA + 8'd10);
        end else begin
            is_hex = 1'b0;
        end
    end

    assign len_inc = (i_scan.len < LEN_LIMIT) ? i_scan.len + 8'd1 : i_scan.len;

    logic take, fin, found;

    always_comb begin
        o_scan = i_scan;
        take   = 1'b0;
        fin    = 1'b0;
        found  = 1'b1;
        o_emit = 1'b0;
        case (i_scan.phase)
            PH_IDLE, PH_SIGNED: begin
                if (i_scan.phase == PH_IDLE) begin
                    o_scan.minus = 1'b0;
                    o_scan.kind  = K_DEC;
                    o_scan.acc   = '0;
                    o_scan.nacc  = '0;
                    o_scan.len   = '0;
                end
                if (is_sign && (i_scan.phase == PH_IDLE)) begin
                    o_scan.len   = (LEN_LIMIT > 8'd0) ? 8'd1 : 8'd0;
                    o_scan.minus = (i_char == CH_MINUS);
                    o_scan.phase = PH_SIGNED;
                    o_emit       = i_eot;
                    found        = 1'b0;
                end else if (is_dig) begin
                    o_scan.len   = (i_scan.phase == PH_IDLE) ?
                                   ((LEN_LIMIT > 8'd0) ? 8'd1 : 8'd0) : len_inc;
                    o_scan.acc   = {60'd0, dig};
                    o_scan.nacc  = 64'd0 - {60'd0, dig};
                    o_scan.kind  = K_DEC;
                    o_scan.phase = (dig == 4'd0) ? PH_ZERO : PH_INT;
                    o_emit       = i_eot;
                end else begin
                    o_emit = 1'b1;
                    found  = 1'b0;
                end
            end
            default: begin
                case (i_scan.phase)
                    PH_INT: begin
                        if (is_dig) begin
                            take        = 1'b1;
                            o_scan.acc  = (i_scan.acc << 3) + (i_scan.acc << 1)
                                          + {60'd0, dig};
                            o_scan.nacc = (i_scan.nacc << 3) + (i_scan.nacc << 1)
                                          - {60'd0, dig};
                        end else if (i_char == CH_DOT) begin
                            take = 1'b1; o_scan.phase = PH_FRAC; o_scan.kind = K_DBL;
                        end else if (is_e) begin
                            take = 1'b1; o_scan.phase = PH_ESIGN; o_scan.kind = K_DBL;
                        end
                    end
                    PH_FRAC: begin
                        if (is_dig) begin
                            take = 1'b1;
                        end else if (is_e) begin
                            take = 1'b1; o_scan.phase = PH_ESIGN;
                        end else if (is_f) begin
                            take = 1'b1; fin = 1'b1; o_scan.kind = K_FLT;
                        end
                    end
                    PH_ESIGN: begin
                        if (is_sign || is_dig) begin
                            take = 1'b1; o_scan.phase = PH_EXP;
                        end else if (is_f) begin
                            take = 1'b1; fin = 1'b1; o_scan.kind = K_FLT;
                        end
                    end
                    PH_EXP: begin
                        if (is_dig) begin
                            take = 1'b1;
                        end else if (is_f) begin
                            take = 1'b1; fin = 1'b1; o_scan.kind = K_FLT;
                        end
                    end
                    PH_ZERO: begin
                        if ((i_char == CH_LX) || (i_char == CH_UX)) begin
                            take = 1'b1; o_scan.phase = PH_HEX; o_scan.kind = K_HEX;
                            o_scan.acc = '0; o_scan.nacc = '0;
                        end else if ((i_char == CH_LB) || (i_char == CH_UB)) begin
                            take = 1'b1; o_scan.phase = PH_BIN; o_scan.kind = K_BIN;
                            o_scan.acc = '0; o_scan.nacc = '0;
                        end else if (is_oct) begin
                            take = 1'b1; o_scan.phase = PH_OCT; o_scan.kind = K_OCT;
                            o_scan.acc  = {60'd0, dig};
                            o_scan.nacc = 64'd0 - {60'd0, dig};
                        end else if (i_char == CH_DOT) begin
                            take = 1'b1; o_scan.phase = PH_FRAC; o_scan.kind = K_DBL;
                        end
                    end
                    PH_HEX: begin
                        if (is_hex) begin
                            take        = 1'b1;
                            o_scan.acc  = (i_scan.acc << 4) + {60'd0, hexv};
                            o_scan.nacc = (i_scan.nacc << 4) - {60'd0, hexv};
                        end
                    end
                    PH_BIN: begin
                        if (is_bin) begin
                            take        = 1'b1;
                            o_scan.acc  = (i_scan.acc << 1) + {63'd0, dig[0]};
                            o_scan.nacc = (i_scan.nacc << 1) - {63'd0, dig[0]};
                        end
                    end
                    PH_OCT: begin
                        if (is_oct) begin
                            take        = 1'b1;
                            o_scan.acc  = (i_scan.acc << 3) + {61'd0, dig[2:0]};
                            o_scan.nacc = (i_scan.nacc << 3) - {61'd0, dig[2:0]};
                        end
                    end
                    default: begin
                        take = 1'b0;
                    end
                endcase
                if (take) begin
                    o_scan.len = len_inc;
                    o_emit     = fin || i_eot;
                end else begin
                    o_emit = 1'b1;
                end
            end
        endcase
        if (o_emit) begin
            o_scan.phase = PH_IDLE;
        end
    end

    logic [31:0] oct_w;
    assign oct_w = o_scan.minus ? o_scan.nacc[31:0] : o_scan.acc[31:0];

    always_comb begin
        o_result.had_minus = o_scan.minus;
        o_result.len       = o_scan.len;
        o_result.found     = found;
        o_result.kind      = found ? o_scan.kind : K_DEC;
        o_result.value     = '0;
        if (found) begin
            case (o_scan.kind)
                K_OCT:               o_result.value = {{32{oct_w[31]}}, oct_w};
                K_DEC, K_HEX, K_BIN: o_result.value = o_scan.minus ? o_scan.nacc
                                                                   : o_scan.acc;
                default:             o_result.value = '0;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/nll_obuf.sv
`default_nettype none
module nll_obuf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire nll_pkg::t_result i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    input  wire logic             i_pop,
    output nll_pkg::t_result      o_data
);
    import nll_pkg::*;

    // two-entry result queue: keeps input side running while output stalls
    t_result    r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];
    assign do_pop  = o_valid && i_pop;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (do_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, do_pop};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != 2'd2 || do_pop)) else $error("push into full queue");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with count");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !do_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("push lost");

endmodule
`default_nettype wire

FILE: rtl/numeric_literal_lexer.sv
`default_nettype none
// Channel | Dir | tdata (low bit up)                                 | tuser / tlast
// s_axis  | in  | text_char[7:0]                                     | tlast: end_of_text
// m_axis  | out | value[63:0], length[71:64], minus[72], pad[79:73]  | found[0], kind[3:1]
//
// One character per cycle while s_axis_tready is high: each transaction updates the
// registered scan state (shift-add of the 64-bit accumulator).
// A result enters the result queue when its ending character is taken and is shown on m_axis after those ahead of it.
// Synchronous active-low reset returns the lexer to idle and empties the queue.
// A two-entry result queue lets input continue while m_axis is stalled;
// s_axis_tready drops only when both queue entries are occupied.
module numeric_literal_lexer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [nll_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // text_char
    input  wire logic                            s_axis_tlast,  // end_of_text
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // integer_value, consumed_length, had_minus, zero pad
    output logic [nll_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    // number_found, literal_kind
    output logic [nll_pkg::M_TUSER_W-1:0]        m_axis_tuser
);
    import nll_pkg::*;

    t_scan   r_scan, n_scan;
    t_result step_res, q_res;
    logic    step_emit, s_accept, q_ready;

    assign s_axis_tready = q_ready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    nll_step u_step (
        .i_scan   (r_scan),
        .i_char   (s_axis_tdata),
        .i_eot    (s_axis_tlast),
        .o_scan   (n_scan),
        .o_emit   (step_emit),
        .o_result (step_res)
    );

    // scan state advances only on an accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.phase <= PH_IDLE;
            r_scan.minus <= 1'b0;
            r_scan.kind  <= K_DEC;
            r_scan.acc   <= '0;
            r_scan.nacc  <= '0;
            r_scan.len   <= '0;
        end else if (s_accept) begin
            r_scan <= n_scan;
        end
    end

    nll_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_accept && step_emit),
        .i_data  (step_res),
        .o_ready (q_ready),
        .o_valid (m_axis_tvalid),
        .i_pop   (m_axis_tready),
        .o_data  (q_res)
    );

    assign m_axis_tdata = {7'd0, q_res.had_minus, q_res.len, q_res.value};
    assign m_axis_tuser = {q_res.kind, q_res.found};

endmodule
`default_nettype wire
